### hw/rtl/ga_pkg.sv
// Shared constants, types and helper functions of the grid A* planner.
package ga_pkg;

	// Grid geometry: the 6-bit cell fields fix a 64 x 64 store.
	localparam int CW         = 6;
	localparam int MAX_WIDTH  = 1 << CW;
	localparam int MAX_HEIGHT = 1 << CW;
	localparam int CELL_W     = 2 * CW;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int DIM_W      = CW + 1;
	localparam int PLEN_W     = CELL_W + 1;
	localparam int CFG_W      = 7;

	// Fixed-point costs.
	localparam int FRAC_BITS  = 8;
	localparam int COST_W     = 21;
	localparam int ENT_W      = COST_W + CELL_W;
	localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

	// Square-root unit sizing.
	localparam int SUMSQ_W = 2 * CW + 1;
	localparam int RAD_W   = ((SUMSQ_W + 2 * FRAC_BITS + 1) / 2) * 2;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int ITER_W  = $clog2(ROOT_W);

	localparam int HEAP_DEPTH_DEF = 4096;

	function automatic logic [31:0] isqrt_const(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		longint unsigned x;
		r = 0;
		b = 64'd1 << 62;
		x = v;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	localparam logic [31:0] STRAIGHT_COST = 32'd1 << FRAC_BITS;
	localparam logic [31:0] DIAG_COST     = isqrt_const(64'd2 << (2 * FRAC_BITS));

	// Opcodes, status codes, register indexes, cell classes.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_PLAN  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOPATH   = 2'd1;
	localparam logic [1:0] ST_BLOCKED  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ALLOW_DIAG  = 2'd2;
	localparam logic [1:0] REG_ALLOW_UNK   = 2'd3;

	localparam logic [1:0] CLASS_FREE    = 2'd0;
	localparam logic [1:0] CLASS_UNKNOWN = 2'd2;

	// Neighbour offsets: four straight moves, then four diagonals.
	localparam logic signed [1:0] STEP_DX [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
		2'sd1, 2'sd1, -2'sd1, -2'sd1};
	localparam logic signed [1:0] STEP_DY [8] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
		2'sd1, -2'sd1, 2'sd1, -2'sd1};

	typedef struct packed {
		logic          start;
		logic [CW-1:0] dx;
		logic [CW-1:0] dy;
	} sq_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sq_rsp_t;

	function automatic logic passable(logic [1:0] c, logic unk);
		return (c == CLASS_FREE) || ((c == CLASS_UNKNOWN) && unk);
	endfunction

	// Heap order: f first, then cell index.
	function automatic logic ent_less(logic [ENT_W-1:0] a, logic [ENT_W-1:0] b);
		return a < b;
	endfunction

endpackage

### hw/rtl/ga_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ga_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/ga_isqrt.sv
// Bit-serial integer square root of (dx^2 + dy^2) scaled by the cost fraction.
module ga_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  ga_pkg::sq_req_t req,
	output ga_pkg::sq_rsp_t rsp
);
	import ga_pkg::*;

	logic [RAD_W-1:0]   v_q, r_q, bit_q;
	logic [ITER_W-1:0]  it_q;
	logic               busy_q, done_q;
	logic [RAD_W-1:0]   trial;
	logic [SUMSQ_W-1:0] sumsq;

	always_comb begin
		trial = r_q + bit_q;
		sumsq = SUMSQ_W'(req.dx) * SUMSQ_W'(req.dx) + SUMSQ_W'(req.dy) * SUMSQ_W'(req.dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
			it_q   <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
				v_q    <= RAD_W'(sumsq) << (2 * FRAC_BITS);
				r_q    <= '0;
				bit_q  <= RAD_W'(1) << (RAD_W - 2);
			end else if (busy_q) begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (it_q == ITER_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					it_q <= it_q + ITER_W'(1);
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = r_q[ROOT_W-1:0];
endmodule

### hw/rtl/grid_astar_path_planner.sv
// Top level of the grid A* planner: sequencer, cost/map/heap/path stores.
//
// Input channel (in_valid/in_stall) carries one command beat: write a cell
// class, plan from cell_x/cell_y to goal_x/goal_y, read the next path cell,
// or no-op. Every command beat yields exactly one result beat on the output
// channel (out_valid/out_stall): status, path_x/path_y, path_len, last.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
//
// Cell writes and no-ops answer in the cycle after the beat is taken; a path
// read first waits on the registered path store read. A plan runs the start
// and goal checks, then a pass over the whole store that resets the cost
// store, then per expanded cell a heap pop, a test per neighbour and, per
// improved neighbour, a heuristic square root plus a heap push. A found
// route is then stored one path cell at a time. The square-root unit is
// shared by every push and the heap RAM has a single read port.
//
// After reset the cell map is swept to free, one cell a cycle across the
// whole store; no command beat is taken meanwhile (config writes are). While a
// result beat is stalled no new command is taken; the held result stays.
module grid_astar_path_planner #(
	parameter int HEAP_DEPTH = ga_pkg::HEAP_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                opcode,
	input  logic [ga_pkg::CW-1:0]     cell_x,
	input  logic [ga_pkg::CW-1:0]     cell_y,
	input  logic [1:0]                cell_class,
	input  logic [ga_pkg::CW-1:0]     goal_x,
	input  logic [ga_pkg::CW-1:0]     goal_y,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [ga_pkg::CW-1:0]     path_x,
	output logic [ga_pkg::CW-1:0]     path_y,
	output logic [ga_pkg::PLEN_W-1:0] path_len,
	output logic                      last,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [ga_pkg::CFG_W-1:0]  cfg_data
);
	import ga_pkg::*;

	localparam int HI_W = $clog2(HEAP_DEPTH);
	localparam int HC_W = HI_W + 1;

	typedef enum logic [4:0] {
		S_CLRMAP, S_IDLE, S_RDW, S_PS, S_PG, S_CLR, S_INIT, S_HST, S_HWT,
		S_PUCHK, S_PUTST, S_PUCMP, S_NBNX, S_POP, S_PO0, S_POL, S_SIFT,
		S_C1, S_C2, S_CUR, S_CURD, S_NB, S_NBD, S_GCHK, S_PW, S_PR
	} state_t;

	state_t state_q;

	// configuration
	logic [CFG_W-1:0] grid_width_q, grid_height_q;
	logic             diag_q, unk_q;
	logic [DIM_W-1:0] w_eff, h_eff;

	// plan registers
	logic [CW-1:0]     sx_q, sy_q, gx_q, gy_q;
	logic              ok_s_q;
	logic [CELL_W-1:0] clr_q, cur_q, nb_q, top_cell_q, at_q, j_q;
	logic [COST_W-1:0] g_q, t_q;
	logic [2:0]        dir_q;
	logic [HC_W-1:0]   cnt_q;
	logic [HI_W-1:0]   hi_q, cidx_q;
	logic [ENT_W-1:0]  he_q, child_q;
	logic [PLEN_W-1:0] pc_q, rp_q;

	// result register
	logic              out_valid_q, last_q;
	logic [1:0]        status_q;
	logic [CW-1:0]     path_x_q, path_y_q;
	logic [PLEN_W-1:0] path_len_q;

	// memory ports
	logic                map_we, cost_we, from_we, heap_we, path_we;
	logic [CELL_W-1:0]   map_wa, map_ra, cost_wa, cost_ra, from_wa, from_ra;
	logic [CELL_W-1:0]   path_wa, path_ra, from_wd, from_rd, path_wd, path_rd;
	logic [1:0]          map_wd, map_rd;
	logic [COST_W:0]     cost_wd, cost_rd;
	logic [HI_W-1:0]     heap_wa, heap_ra;
	logic [ENT_W-1:0]    heap_wd, heap_rd;

	sq_req_t sq_req;
	sq_rsp_t sq_rsp;

	// datapath helpers
	logic              in_acc, out_take, nb_out, relax, use2, swap;
	logic [CELL_W-1:0] start_cell, goal_cell, nb_calc;
	logic signed [1:0] sdx, sdy;
	logic [DIM_W-1:0]  nx7, ny7;
	logic [COST_W-1:0] move_cost, t_new;
	logic [HI_W-1:0]   parent, cand_i;
	logic [HC_W-1:0]   c_full, c1;
	logic [ENT_W-1:0]  cand_e;
	logic [CW-1:0]     nbx, nby;

	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);

	always_comb begin
		w_eff = (grid_width_q > CFG_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width_q;
		h_eff = (grid_height_q > CFG_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height_q;
		start_cell = {sy_q, sx_q};
		goal_cell  = {gy_q, gx_q};
		sdx = STEP_DX[dir_q];
		sdy = STEP_DY[dir_q];
		nx7 = {1'b0, cur_q[CW-1:0]} + {{(CW-1){sdx[1]}}, sdx};
		ny7 = {1'b0, cur_q[CELL_W-1:CW]} + {{(CW-1){sdy[1]}}, sdy};
		// a step off the low edge wraps high, so one compare covers both sides
		nb_out  = (nx7 >= w_eff) || (ny7 >= h_eff);
		nb_calc = {ny7[CW-1:0], nx7[CW-1:0]};
		move_cost = dir_q[2] ? COST_W'(DIAG_COST) : COST_W'(STRAIGHT_COST);
		t_new = g_q + move_cost;
		relax = passable(map_rd, unk_q) && !cost_rd[COST_W] &&
			(t_new < cost_rd[COST_W-1:0]);
		parent = (hi_q - HI_W'(1)) >> 1;
		c_full = {hi_q, 1'b1};
		c1     = {1'b0, cidx_q} + HC_W'(1);
		use2   = (state_q == S_C2) && ent_less(heap_rd, child_q);
		cand_e = ((state_q == S_C2) && !use2) ? child_q : heap_rd;
		cand_i = use2 ? c1[HI_W-1:0] : cidx_q;
		swap   = ent_less(cand_e, he_q);
		nbx = nb_q[CW-1:0];
		nby = nb_q[CELL_W-1:CW];
	end

	// memory port control
	always_comb begin
		map_we  = 1'b0;
		map_wa  = clr_q;
		map_wd  = CLASS_FREE;
		map_ra  = nb_calc;
		cost_we = 1'b0;
		cost_wa = clr_q;
		cost_wd = {1'b0, COST_INF};
		cost_ra = nb_calc;
		from_we = 1'b0;
		from_wa = nb_q;
		from_wd = cur_q;
		from_ra = at_q;
		heap_we = 1'b0;
		heap_wa = hi_q;
		heap_wd = he_q;
		heap_ra = '0;
		path_we = 1'b0;
		path_wa = ~j_q;
		path_wd = at_q;
		path_ra = rp_q[CELL_W-1:0] - pc_q[CELL_W-1:0];
		sq_req.start = 1'b0;
		sq_req.dx = (nbx > gx_q) ? nbx - gx_q : gx_q - nbx;
		sq_req.dy = (nby > gy_q) ? nby - gy_q : gy_q - nby;
		unique case (state_q)
			S_CLRMAP: map_we = 1'b1;
			S_IDLE: begin
				map_ra = {cell_y, cell_x};
				if (in_acc && opcode == OP_WRITE) begin
					map_we = 1'b1;
					map_wa = {cell_y, cell_x};
					map_wd = cell_class;
				end
			end
			S_PS:  map_ra = goal_cell;
			S_CLR: cost_we = 1'b1;
			S_INIT: begin
				cost_we = 1'b1;
				cost_wa = start_cell;
				cost_wd = '0;
			end
			S_HST: sq_req.start = 1'b1;
			S_PUTST: begin
				if (hi_q == '0) heap_we = 1'b1;
				else heap_ra = parent;
			end
			S_PUCMP: begin
				heap_we = 1'b1;
				heap_wd = ent_less(he_q, heap_rd) ? heap_rd : he_q;
			end
			S_POP: cost_ra = goal_cell;
			S_PO0: heap_ra = cnt_q[HI_W-1:0];
			S_SIFT: begin
				if (c_full < cnt_q) heap_ra = c_full[HI_W-1:0];
				else heap_we = 1'b1;
			end
			S_C1: begin
				if (c1 < cnt_q) begin
					heap_ra = c1[HI_W-1:0];
				end else begin
					heap_we = 1'b1;
					heap_wd = swap ? cand_e : he_q;
				end
			end
			S_C2: begin
				heap_we = 1'b1;
				heap_wd = swap ? cand_e : he_q;
			end
			S_CUR: cost_ra = top_cell_q;
			S_CURD: begin
				if (!cost_rd[COST_W]) begin
					cost_we = 1'b1;
					cost_wa = cur_q;
					cost_wd = {1'b1, cost_rd[COST_W-1:0]};
				end
			end
			S_NBD: begin
				if (relax) begin
					cost_we = 1'b1;
					cost_wa = nb_q;
					cost_wd = {1'b0, t_new};
					from_we = 1'b1;
				end
			end
			S_PW: path_we = 1'b1;
			default: ;
		endcase
	end

	// sequencer, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLRMAP;
			grid_width_q  <= CFG_W'(MAX_WIDTH);
			grid_height_q <= CFG_W'(MAX_HEIGHT);
			diag_q        <= 1'b0;
			unk_q         <= 1'b0;
			clr_q         <= '0;
			cnt_q         <= '0;
			pc_q          <= '0;
			rp_q          <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			path_x_q      <= '0;
			path_y_q      <= '0;
			path_len_q    <= '0;
			last_q        <= 1'b0;
			sx_q <= '0; sy_q <= '0; gx_q <= '0; gy_q <= '0;
			ok_s_q <= 1'b0;
			cur_q <= '0; nb_q <= '0; top_cell_q <= '0; at_q <= '0; j_q <= '0;
			g_q <= '0; t_q <= '0; dir_q <= '0;
			hi_q <= '0; cidx_q <= '0; he_q <= '0; child_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					REG_GRID_HEIGHT: grid_height_q <= cfg_data;
					REG_ALLOW_DIAG:  diag_q        <= cfg_data[0];
					REG_ALLOW_UNK:   unk_q         <= cfg_data[0];
				endcase
			end

			if (out_take) out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLRMAP: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						unique case (opcode)
							OP_WRITE, OP_NOP: begin
								out_valid_q <= 1'b1;
								status_q    <= ST_OK;
								path_x_q    <= '0;
								path_y_q    <= '0;
								path_len_q  <= '0;
								last_q      <= 1'b0;
							end
							OP_PLAN: begin
								sx_q    <= cell_x;
								sy_q    <= cell_y;
								gx_q    <= goal_x;
								gy_q    <= goal_y;
								pc_q    <= '0;
								rp_q    <= '0;
								cnt_q   <= '0;
								state_q <= S_PS;
							end
							OP_READ: begin
								if (rp_q < pc_q) begin
									state_q <= S_RDW;
								end else begin
									out_valid_q <= 1'b1;
									status_q    <= ST_NOPATH;
									path_x_q    <= '0;
									path_y_q    <= '0;
									path_len_q  <= pc_q;
									last_q      <= 1'b0;
								end
							end
						endcase
					end
				end
				S_RDW: begin
					out_valid_q <= 1'b1;
					status_q    <= ST_OK;
					path_x_q    <= path_rd[CW-1:0];
					path_y_q    <= path_rd[CELL_W-1:CW];
					path_len_q  <= pc_q;
					last_q      <= (rp_q + PLEN_W'(1)) == pc_q;
					rp_q        <= rp_q + PLEN_W'(1);
					state_q     <= S_IDLE;
				end
				S_PS: begin
					ok_s_q  <= (DIM_W'(sx_q) < w_eff) && (DIM_W'(sy_q) < h_eff) &&
						passable(map_rd, unk_q);
					state_q <= S_PG;
				end
				S_PG: begin
					if (ok_s_q && (DIM_W'(gx_q) < w_eff) && (DIM_W'(gy_q) < h_eff) &&
							passable(map_rd, unk_q)) begin
						clr_q   <= '0;
						state_q <= S_CLR;
					end else begin
						out_valid_q <= 1'b1;
						status_q    <= ST_BLOCKED;
						path_x_q    <= '0;
						path_y_q    <= '0;
						path_len_q  <= '0;
						last_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == '1) state_q <= S_INIT;
				end
				S_INIT: begin
					// start entry: dir at its top so the push falls through to pop
					t_q     <= '0;
					nb_q    <= start_cell;
					dir_q   <= 3'd7;
					state_q <= S_HST;
				end
				S_HST: state_q <= S_HWT;
				S_HWT: begin
					if (sq_rsp.done) begin
						he_q    <= {t_q + COST_W'(sq_rsp.root), nb_q};
						state_q <= S_PUCHK;
					end
				end
				S_PUCHK: begin
					if (cnt_q >= HC_W'(HEAP_DEPTH)) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OVERFLOW;
						path_x_q    <= '0;
						path_y_q    <= '0;
						path_len_q  <= '0;
						last_q      <= 1'b0;
						cnt_q       <= '0;
						state_q     <= S_IDLE;
					end else begin
						hi_q    <= cnt_q[HI_W-1:0];
						cnt_q   <= cnt_q + HC_W'(1);
						state_q <= S_PUTST;
					end
				end
				S_PUTST: begin
					if (hi_q == '0) begin
						state_q <= S_NBNX;
					end else begin
						cidx_q  <= parent;
						state_q <= S_PUCMP;
					end
				end
				S_PUCMP: begin
					if (ent_less(he_q, heap_rd)) begin
						hi_q    <= cidx_q;
						state_q <= S_PUTST;
					end else begin
						state_q <= S_NBNX;
					end
				end
				S_NBNX: begin
					if (dir_q >= (diag_q ? 3'd7 : 3'd3)) begin
						state_q <= S_POP;
					end else begin
						dir_q   <= dir_q + 3'd1;
						state_q <= S_NB;
					end
				end
				S_POP: begin
					if (cnt_q == '0) begin
						state_q <= S_GCHK;
					end else begin
						cnt_q   <= cnt_q - HC_W'(1);
						state_q <= S_PO0;
					end
				end
				S_PO0: begin
					top_cell_q <= heap_rd[CELL_W-1:0];
					state_q    <= (cnt_q == '0) ? S_CUR : S_POL;
				end
				S_POL: begin
					he_q    <= heap_rd;
					hi_q    <= '0;
					state_q <= S_SIFT;
				end
				S_SIFT: begin
					if (c_full < cnt_q) begin
						cidx_q  <= c_full[HI_W-1:0];
						state_q <= S_C1;
					end else begin
						state_q <= S_CUR;
					end
				end
				S_C1: begin
					if (c1 < cnt_q) begin
						child_q <= heap_rd;
						state_q <= S_C2;
					end else if (swap) begin
						hi_q    <= cand_i;
						state_q <= S_SIFT;
					end else begin
						state_q <= S_CUR;
					end
				end
				S_C2: begin
					if (swap) begin
						hi_q    <= cand_i;
						state_q <= S_SIFT;
					end else begin
						state_q <= S_CUR;
					end
				end
				S_CUR: begin
					cur_q   <= top_cell_q;
					state_q <= S_CURD;
				end
				S_CURD: begin
					if (cost_rd[COST_W]) begin
						state_q <= S_POP;
					end else begin
						g_q <= cost_rd[COST_W-1:0];
						if (cur_q == goal_cell) begin
							at_q    <= goal_cell;
							j_q     <= '0;
							state_q <= S_PW;
						end else begin
							dir_q   <= '0;
							state_q <= S_NB;
						end
					end
				end
				S_NB: begin
					if (nb_out) begin
						state_q <= S_NBNX;
					end else begin
						nb_q    <= nb_calc;
						state_q <= S_NBD;
					end
				end
				S_NBD: begin
					if (relax) begin
						t_q     <= t_new;
						state_q <= S_HST;
					end else begin
						state_q <= S_NBNX;
					end
				end
				S_GCHK: begin
					if (cost_rd[COST_W-1:0] == COST_INF) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_NOPATH;
						path_x_q    <= '0;
						path_y_q    <= '0;
						path_len_q  <= '0;
						last_q      <= 1'b0;
						state_q     <= S_IDLE;
					end else begin
						at_q    <= goal_cell;
						j_q     <= '0;
						state_q <= S_PW;
					end
				end
				S_PW: begin
					// path is stored backwards from the top of the store
					if (at_q == start_cell || j_q == '1) begin
						pc_q        <= PLEN_W'(j_q) + PLEN_W'(1);
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						path_x_q    <= '0;
						path_y_q    <= '0;
						path_len_q  <= PLEN_W'(j_q) + PLEN_W'(1);
						last_q      <= 1'b0;
						cnt_q       <= '0;
						state_q     <= S_IDLE;
					end else begin
						j_q     <= j_q + CELL_W'(1);
						state_q <= S_PR;
					end
				end
				S_PR: begin
					at_q    <= from_rd;
					state_q <= S_PW;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign path_x    = path_x_q;
	assign path_y    = path_y_q;
	assign path_len  = path_len_q;
	assign last      = last_q;

	ga_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
		.raddr(map_ra), .rdata(map_rd)
	);

	ga_ram #(.WIDTH(COST_W + 1), .DEPTH(CELLS)) u_cost (
		.clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
		.raddr(cost_ra), .rdata(cost_rd)
	);

	ga_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_from (
		.clk(clk), .we(from_we), .waddr(from_wa), .wdata(from_wd),
		.raddr(from_ra), .rdata(from_rd)
	);

	ga_ram #(.WIDTH(ENT_W), .DEPTH(HEAP_DEPTH)) u_heap (
		.clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
		.raddr(heap_ra), .rdata(heap_rd)
	);

	ga_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
		.clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd),
		.raddr(path_ra), .rdata(path_rd)
	);

	ga_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .req(sq_req), .rsp(sq_rsp)
	);

	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HC_W'(HEAP_DEPTH))
		else $error("heap count beyond depth");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= pc_q)
		else $error("read pointer past stored path");

	a_path_build: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PW) |-> (pc_q == '0))
		else $error("stored length set while path is built");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDW) |=> out_valid_q)
		else $error("path read gave no result beat");
endmodule

### dv/grid_astar_path_planner_tb.sv
// Self-checking testbench of the grid A* path planner: directed and random command beats.
module grid_astar_path_planner_tb;
	import ga_pkg::*;

	// Cell classes the package leaves unnamed.
	localparam logic [1:0] CLASS_OCC  = 2'd1;
	localparam logic [1:0] CLASS_RSVD = 2'd3;
	localparam longint unsigned NO_COST = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0]    op;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [1:0]    cls;
		logic [CW-1:0] gx;
		logic [CW-1:0] gy;
	} cmd_t;

	typedef struct {
		logic [1:0]        status;
		logic [CW-1:0]     px;
		logic [CW-1:0]     py;
		logic [PLEN_W-1:0] plen;
		logic              last;
	} beat_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          opcode;
	logic [CW-1:0]       cell_x;
	logic [CW-1:0]       cell_y;
	logic [1:0]          cell_class;
	logic [CW-1:0]       goal_x;
	logic [CW-1:0]       goal_y;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic [CW-1:0]       path_x;
	logic [CW-1:0]       path_y;
	logic [PLEN_W-1:0]   path_len;
	logic                last;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	grid_astar_path_planner dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .cell_x(cell_x), .cell_y(cell_y), .cell_class(cell_class),
		.goal_x(goal_x), .goal_y(goal_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .path_x(path_x), .path_y(path_y), .path_len(path_len),
		.last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Mirror of the planner: map, search scratch, stored route, registers.
	logic [1:0]      occ_map [CELLS];
	longint unsigned g_cost [CELLS];
	int unsigned     parent [CELLS];
	bit              shut [CELLS];
	longint unsigned frontier [$];   // sorted keys {f, cell}
	int unsigned     route [CELLS];
	int unsigned     route_len;
	int unsigned     route_ptr;
	int unsigned     cols_reg, rows_reg, diag_reg, unk_reg;

	beat_t       expected_beats [$];
	beat_t       head;
	int          errors;
	int          idle_pct;
	int          stall_pct;
	int          hold_req;
	int          beats_sent;
	int          move_dx [8] = '{1, -1, 0, 0, 1, 1, -1, -1};
	int          move_dy [8] = '{0, 0, 1, -1, 1, -1, 1, -1};

	// Clock: period 4.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Floor square root by bisection.
	function automatic longint unsigned sqrt_floor(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd1 << 24;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid;
		end
		return lo;
	endfunction

	function automatic longint unsigned euclid(int x0, int y0, int x1, int y1);
		longint unsigned dx, dy;
		dx = (x0 > x1) ? x0 - x1 : x1 - x0;
		dy = (y0 > y1) ? y0 - y1 : y1 - y0;
		return sqrt_floor((dx * dx + dy * dy) << (2 * FRAC_BITS));
	endfunction

	function automatic bit walkable(int x, int y, int w, int h);
		logic [1:0] c;
		if (x < 0 || y < 0 || x >= w || y >= h) return 0;
		c = occ_map[y * MAX_WIDTH + x];
		return c == CLASS_FREE || (c == CLASS_UNKNOWN && unk_reg != 0);
	endfunction

	// Frontier kept sorted on {f, cell}; equal keys are interchangeable.
	function automatic bit frontier_push(longint unsigned f, int unsigned c);
		longint unsigned key;
		int pos;
		if (frontier.size() >= HEAP_DEPTH_DEF) return 0;
		key = (f << CELL_W) | c;
		pos = frontier.size();
		while (pos > 0 && frontier[pos-1] > key) pos--;
		frontier.insert(pos, key);
		return 1;
	endfunction

	function automatic logic [1:0] search(int sx, int sy, int gx, int gy);
		int w, h, cx, cy, nx, ny, nd, n;
		int unsigned start, goal, cur, ni, at;
		longint unsigned diag, t, key;
		w = (cols_reg > MAX_WIDTH) ? MAX_WIDTH : cols_reg;
		h = (rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : rows_reg;
		diag = sqrt_floor(64'd2 << (2 * FRAC_BITS));
		nd = diag_reg ? 8 : 4;
		route_len = 0;
		route_ptr = 0;
		frontier.delete();
		if (!walkable(sx, sy, w, h) || !walkable(gx, gy, w, h)) return ST_BLOCKED;
		for (int i = 0; i < CELLS; i++) begin
			g_cost[i] = NO_COST;
			parent[i] = 0;
			shut[i] = 0;
		end
		start = sy * MAX_WIDTH + sx;
		goal = gy * MAX_WIDTH + gx;
		g_cost[start] = 0;
		void'(frontier_push(euclid(sx, sy, gx, gy), start));
		while (frontier.size() > 0) begin
			key = frontier.pop_front();
			cur = int'(key & (CELLS - 1));
			if (shut[cur]) continue;
			shut[cur] = 1;
			if (cur == goal) break;
			cx = cur % MAX_WIDTH;
			cy = cur / MAX_WIDTH;
			for (int d = 0; d < nd; d++) begin
				nx = cx + move_dx[d];
				ny = cy + move_dy[d];
				if (!walkable(nx, ny, w, h)) continue;
				ni = ny * MAX_WIDTH + nx;
				if (shut[ni]) continue;
				t = g_cost[cur] + ((d >= 4) ? diag : 64'd1 << FRAC_BITS);
				if (t < g_cost[ni]) begin
					g_cost[ni] = t;
					parent[ni] = cur;
					if (!frontier_push(t + euclid(nx, ny, gx, gy), ni)) begin
						frontier.delete();
						return ST_OVERFLOW;
					end
				end
			end
		end
		frontier.delete();
		if (g_cost[goal] == NO_COST) return ST_NOPATH;
		n = 1;
		at = goal;
		while (at != start && n < CELLS) begin
			at = parent[at] % CELLS;
			n++;
		end
		at = goal;
		for (int k = n; k > 0; k--) begin
			route[k-1] = at;
			at = parent[at] % CELLS;
		end
		route_len = n;
		return ST_OK;
	endfunction

	function automatic beat_t planner_response(cmd_t c);
		beat_t r;
		int unsigned rc;
		r = '{default: '0};
		case (c.op)
			OP_WRITE: begin
				occ_map[c.y * MAX_WIDTH + c.x] = c.cls;
			end
			OP_PLAN: begin
				r.status = search(c.x, c.y, c.gx, c.gy);
				r.plen = PLEN_W'(route_len);
			end
			OP_READ: begin
				r.plen = PLEN_W'(route_len);
				if (route_ptr < route_len) begin
					rc = route[route_ptr];
					r.px = CW'(rc % MAX_WIDTH);
					r.py = CW'(rc / MAX_WIDTH);
					r.last = (route_ptr + 1 == route_len);
					route_ptr++;
				end else begin
					r.status = ST_NOPATH;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_t mk(logic [1:0] op, int x, int y, logic [1:0] cls, int gx, int gy);
		cmd_t c;
		c.op = op;
		c.x = CW'(x);
		c.y = CW'(y);
		c.cls = cls;
		c.gx = CW'(gx);
		c.gy = CW'(gy);
		return c;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
		errors++;
	endtask

	// One command beat: random gaps before it, held until taken.
	task automatic send_cmd(cmd_t c);
		beat_t r;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= c.op;
		cell_x     <= c.x;
		cell_y     <= c.y;
		cell_class <= c.cls;
		goal_x     <= c.gx;
		goal_y     <= c.gy;
		do @(posedge clk); while (in_stall);
		r = planner_response(c);
		expected_beats.insert(expected_beats.size(), r);
		beats_sent++;
	endtask

	task automatic plan_to(int sx, int sy, int gx, int gy);
		send_cmd(mk(OP_PLAN, sx, sy, CLASS_FREE, gx, gy));
	endtask

	task automatic read_cells(int n);
		for (int i = 0; i < n; i++)
			send_cmd(mk(OP_READ, $urandom, $urandom, 2'($urandom), $urandom, $urandom));
	endtask

	// Sender pauses until every expected beat is back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_beats.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, int v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GRID_WIDTH:  cols_reg = v & 8'h7F;
			REG_GRID_HEIGHT: rows_reg = v & 8'h7F;
			REG_ALLOW_DIAG:  diag_reg = v & 1;
			default:         unk_reg = v & 1;
		endcase
	endtask

	task automatic configure(int w, int h, int dg, int uk);
		drain();
		set_reg(REG_GRID_WIDTH, w);
		set_reg(REG_GRID_HEIGHT, h);
		set_reg(REG_ALLOW_DIAG, dg);
		set_reg(REG_ALLOW_UNK, uk);
	endtask

	// Reset settings: straight route, start on goal, blocked goal, reads past the end.
	task automatic test_reset_settings();
		send_cmd(mk(OP_WRITE, 63, 63, CLASS_OCC, 0, 0));
		send_cmd(mk(OP_WRITE, 0, 0, CLASS_FREE, 63, 63));
		read_cells(1);
		plan_to(0, 0, 0, 0);
		read_cells(2);
		plan_to(0, 0, 63, 63);
		read_cells(1);
		plan_to(0, 0, 5, 0);
		read_cells(7);
		send_cmd(mk(OP_NOP, 63, 63, CLASS_RSVD, 63, 63));
		drain();
	endtask

	// Register extremes: empty grid, oversize width, one row, one cell.
	task automatic test_grid_limits();
		configure(0, 64, 0, 0);
		plan_to(0, 0, 0, 0);
		configure(127, 1, 0, 0);
		plan_to(0, 0, 63, 0);
		read_cells(2);
		plan_to(0, 0, 0, 1);
		configure(1, 1, 1, 1);
		plan_to(0, 0, 0, 0);
		read_cells(1);
		drain();
	endtask

	// Walls, unknown cells, reserved class, diagonal moves.
	task automatic test_map_classes();
		configure(3, 3, 0, 0);
		for (int y = 0; y < 3; y++) send_cmd(mk(OP_WRITE, 1, y, CLASS_OCC, 0, 0));
		plan_to(0, 0, 2, 0);
		send_cmd(mk(OP_WRITE, 1, 1, CLASS_UNKNOWN, 0, 0));
		plan_to(0, 0, 2, 0);
		configure(3, 3, 1, 1);
		plan_to(0, 0, 2, 0);
		read_cells(4);
		send_cmd(mk(OP_WRITE, 0, 0, CLASS_RSVD, 0, 0));
		plan_to(0, 0, 2, 2);
		plan_to(5, 0, 2, 2);
		send_cmd(mk(OP_WRITE, 0, 0, CLASS_FREE, 0, 0));
		configure(64, 64, 1, 0);
		plan_to(0, 0, 63, 63);
		read_cells(3);
		drain();
	endtask

	function automatic int pick_dim();
		int r;
		r = $urandom_range(99);
		if (r < 3) return 0;
		if (r < 6) return 127;
		if (r < 9) return 64;
		return $urandom_range(1, 10);
	endfunction

	// Random scenarios: map edits, one plan, then reads of the route and beyond.
	task automatic test_random(int n_beats);
		int w, h, sx, sy, gx, gy, goal_stop;
		goal_stop = beats_sent + n_beats;
		while (beats_sent < goal_stop) begin
			configure(pick_dim(), pick_dim(), $urandom_range(1), $urandom_range(1));
			w = (cols_reg > MAX_WIDTH) ? MAX_WIDTH : cols_reg;
			h = (rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : rows_reg;
			for (int i = $urandom_range(4, 25); i > 0; i--) begin
				if ($urandom_range(99) < 10 || w == 0 || h == 0)
					send_cmd(mk(OP_WRITE, $urandom, $urandom, 2'($urandom),
						$urandom, $urandom));
				else
					send_cmd(mk(OP_WRITE, $urandom_range(w - 1), $urandom_range(h - 1),
						($urandom_range(99) < 55) ? CLASS_FREE : 2'($urandom),
						$urandom, $urandom));
				if ($urandom_range(99) < 8) send_cmd(mk(OP_NOP, $urandom, $urandom,
					2'($urandom), $urandom, $urandom));
			end
			if ($urandom_range(99) < 15 || w == 0 || h == 0) begin
				sx = $urandom_range(63);
				sy = $urandom_range(63);
				gx = $urandom_range(63);
				gy = $urandom_range(63);
			end else begin
				// large grids: keep the goal near the start, the search stays short
				sx = $urandom_range(w - 1);
				sy = $urandom_range(h - 1);
				gx = (w > 16) ? (sx + $urandom_range(8)) % w : $urandom_range(w - 1);
				gy = (h > 16) ? (sy + $urandom_range(8)) % h : $urandom_range(h - 1);
			end
			plan_to(sx, sy, gx, gy);
			read_cells(route_len + $urandom_range(2));
		end
		drain();
	endtask

	// Long receiver hold-off while beats keep coming, then a full drain.
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		configure(4, 4, 0, 0);
		hold_req = 300;
		for (int i = 0; i < 12; i++)
			send_cmd(mk(OP_WRITE, $urandom_range(3), $urandom_range(3), CLASS_FREE, 0, 0));
		plan_to(0, 0, 3, 3);
		read_cells(8);
		drain();
	endtask

	// Receiver: random stalls, or a counted hold-off when one is asked for.
	always @(negedge clk) begin : stall_gen
		int hold_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Result check: each beat taken against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				report("unexpected beat, status", status, -1);
			end else begin
				head = expected_beats.pop_front();
				if (status !== head.status) report("status", status, head.status);
				if (path_x !== head.px) report("path_x", path_x, head.px);
				if (path_y !== head.py) report("path_y", path_y, head.py);
				if (path_len !== head.plen) report("path_len", path_len, head.plen);
				if (last !== head.last) report("last", last, head.last);
			end
		end
	end

	initial begin
		#100000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_NOP;
		cell_x = '0;
		cell_y = '0;
		cell_class = CLASS_FREE;
		goal_x = '0;
		goal_y = '0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = '0;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		beats_sent = 0;
		cols_reg = 64;
		rows_reg = 64;
		diag_reg = 0;
		unk_reg = 0;
		route_len = 0;
		route_ptr = 0;
		for (int i = 0; i < CELLS; i++) occ_map[i] = CLASS_FREE;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, with mild idling and stalls on the grid-limit test only.
		test_reset_settings();
		idle_pct = 30;
		stall_pct = 30;
		test_grid_limits();
		idle_pct = 0;
		stall_pct = 0;
		test_map_classes();

		// Random phases: none, sender gaps, receiver stalls, both.
		idle_pct = 0;  stall_pct = 0;  test_random(500);
		idle_pct = 62; stall_pct = 0;  test_random(500);
		idle_pct = 0;  stall_pct = 62; test_random(500);
		idle_pct = 30; stall_pct = 30; test_random(500);

		test_backpressure();

		stall_pct = 0;
		wait (expected_beats.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
